// ----- src/spl_pkg.sv -----
// Package for the sieve prime lister: sizes, the sequencer state type and the
// saturation helper. No dependencies.
package spl_pkg;

  localparam int unsigned MaxN      = 256;
  localparam int unsigned MarkDepth = MaxN + 1;
  localparam int unsigned AddrW     = $clog2(MarkDepth);
  localparam int unsigned ValueW    = 9;
  localparam int unsigned IndexW    = 7;
  localparam int unsigned SumW      = ValueW + 1;
  localparam int unsigned FirstCand = 2;

  typedef logic [ValueW-1:0] value_t;
  typedef logic [IndexW-1:0] index_t;
  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [SumW-1:0]   sum_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NONE,
    ST_FILL,
    ST_READ,
    ST_CHECK,
    ST_CLEAR,
    ST_NEXT,
    ST_FINISH
  } spl_state_e;

  // Limits above the store size are clipped to its top entry.
  function automatic value_t spl_saturate(input value_t lim);
    value_t top;
    top = ValueW'(MaxN);
    return (lim > top) ? top : lim;
  endfunction

endpackage

// ----- src/spl_mark_ram.sv -----
// One-bit mark store of the sieve: one write port and one read port with
// registered read data. Depends on spl_pkg.
module spl_mark_ram (
  input  logic          clk_i,
  input  logic          we_i,
  input  spl_pkg::addr_t waddr_i,
  input  logic          wdata_i,
  input  spl_pkg::addr_t raddr_i,
  output logic          rdata_o
);
  import spl_pkg::*;

  logic mem_q [MarkDepth];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/sieve_prime_lister.sv -----
// Top level of the sieve prime lister: sequencer, shared adder and output
// register. Depends on spl_pkg and spl_mark_ram.

// The block takes one upper limit n (clipped to 256) and lists every prime up
// to n in ascending order with its 1-based index, flagging the last one; a
// limit below 2 gives one result with none_found and last set. One limit is
// worked on at a time and in_stall_o stays high until the run is done. A run
// first sets the mark store for every value from 2 to n, then reads and
// checks each candidate from 2 to n in turn, clearing every multiple of each
// prime found; output stalls hold the run, and the single adder and the
// single write port of the mark store set its pace.
module sieve_prime_lister (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  spl_pkg::value_t upper_limit_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output spl_pkg::value_t prime_value_o,
  output spl_pkg::index_t prime_index_o,
  output logic           last_o,
  output logic           none_found_o
);
  import spl_pkg::*;

  spl_state_e state_q, state_d;
  value_t     limit_q, limit_d;
  value_t     cand_q, cand_d;
  value_t     mult_q, mult_d;
  index_t     cnt_q, cnt_d;
  value_t     pend_val_q, pend_val_d;
  index_t     pend_idx_q, pend_idx_d;
  logic       have_pend_q, have_pend_d;

  logic       out_valid_q, out_valid_d;
  value_t     out_val_q, out_val_d;
  index_t     out_idx_q, out_idx_d;
  logic       out_last_q, out_last_d;
  logic       out_none_q, out_none_d;

  value_t     add_a, add_b;
  sum_t       sum;
  logic       sum_over;
  logic       out_free;
  value_t     in_lim;

  logic       mem_we;
  addr_t      mem_waddr;
  logic       mem_wdata;
  logic       mem_rdata;

  spl_mark_ram u_mark (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(AddrW'(cand_q)),
    .rdata_o(mem_rdata)
  );

  // The one adder serves both the candidate step and the multiple step.
  assign sum      = {1'b0, add_a} + {1'b0, add_b};
  assign sum_over = sum > {1'b0, limit_q};
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_lim   = spl_saturate(upper_limit_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= '0;
      cand_q      <= '0;
      mult_q      <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      have_pend_q <= have_pend_d;
      out_valid_q <= out_valid_d;
      limit_q     <= limit_d;
      cand_q      <= cand_d;
      mult_q      <= mult_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_val_q <= pend_val_d;
    pend_idx_q <= pend_idx_d;
    out_val_q  <= out_val_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
    out_none_q <= out_none_d;
  end

  always_comb begin
    state_d     = state_q;
    limit_d     = limit_q;
    cand_d      = cand_q;
    mult_d      = mult_q;
    cnt_d       = cnt_q;
    pend_val_d  = pend_val_q;
    pend_idx_d  = pend_idx_q;
    have_pend_d = have_pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_val_d   = out_val_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    out_none_d  = out_none_q;
    add_a       = cand_q;
    add_b       = ValueW'(1);
    mem_we      = 1'b0;
    mem_waddr   = AddrW'(cand_q);
    mem_wdata   = 1'b1;
    in_stall_o  = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          limit_d     = in_lim;
          cand_d      = ValueW'(FirstCand);
          cnt_d       = '0;
          have_pend_d = 1'b0;
          state_d     = (in_lim < ValueW'(FirstCand)) ? ST_NONE : ST_FILL;
        end
      end
      ST_NONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = '0;
          out_idx_d   = '0;
          out_last_d  = 1'b1;
          out_none_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (cand_q == limit_q) begin
          cand_d  = ValueW'(FirstCand);
          state_d = ST_READ;
        end else begin
          cand_d = sum[ValueW-1:0];
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // Read data stays valid here because cand_q does not move.
        if (!mem_rdata) begin
          state_d = ST_NEXT;
        end else if (!have_pend_q || out_free) begin
          if (have_pend_q) begin
            out_valid_d = 1'b1;
            out_val_d   = pend_val_q;
            out_idx_d   = pend_idx_q;
            out_last_d  = 1'b0;
            out_none_d  = 1'b0;
          end
          cnt_d       = cnt_q + IndexW'(1);
          pend_val_d  = cand_q;
          pend_idx_d  = cnt_q + IndexW'(1);
          have_pend_d = 1'b1;
          mult_d      = cand_q;
          state_d     = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = AddrW'(mult_q);
        mem_wdata = 1'b0;
        add_a     = mult_q;
        add_b     = cand_q;
        if (sum_over) begin
          state_d = ST_NEXT;
        end else begin
          mult_d = sum[ValueW-1:0];
        end
      end
      ST_NEXT: begin
        if (sum_over) begin
          state_d = ST_FINISH;
        end else begin
          cand_d  = sum[ValueW-1:0];
          state_d = ST_READ;
        end
      end
      ST_FINISH: begin
        // The prime held back is the last one of the run.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = pend_val_q;
          out_idx_d   = pend_idx_q;
          out_last_d  = 1'b1;
          out_none_d  = 1'b0;
          have_pend_d = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign prime_value_o = out_val_q;
  assign prime_index_o = out_idx_q;
  assign last_o        = out_last_q;
  assign none_found_o  = out_none_q;

`ifndef SYNTHESIS
  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && none_found_o |-> last_o && prime_value_o == '0)
    else $error("none result without last flag or with a value");

  a_index_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !none_found_o |-> prime_index_o != '0)
    else $error("prime result with zero index");

  a_cand_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> cand_q <= limit_q && cand_q >= value_t'(FirstCand))
    else $error("candidate outside the run");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("new limit taken while a run is active");

  a_finish_has_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH |-> have_pend_q)
    else $error("run finished without a held prime");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for sieve_prime_lister: directed and random upper limits,
// bursty input traffic and patterned output stalls, checked against a local sieve.
// Depends on spl_pkg and the sieve_prime_lister RTL.
module testbench;
  import spl_pkg::*;

  localparam int unsigned HoldCycles = 400;
  localparam int unsigned IdleLimit  = 20000;
  localparam int unsigned RandItems  = 236;

  typedef struct packed {
    value_t prime;
    index_t position;
    logic   is_last;
    logic   is_none;
  } prime_rec_t;

  logic   clk_i         = 1'b0;
  logic   rst_ni        = 1'b0;
  logic   in_valid_i    = 1'b0;
  value_t upper_limit_i = '0;
  logic   out_stall_i   = 1'b0;
  logic   in_stall_o;
  logic   out_valid_o;
  value_t prime_value_o;
  index_t prime_index_o;
  logic   last_o;
  logic   none_found_o;

  prime_rec_t  primes_due[$];
  bit          composite_free[0:MaxN];
  int unsigned error_count = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  bit          hold_req    = 1'b0;

  sieve_prime_lister DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .upper_limit_i (upper_limit_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .prime_value_o (prime_value_o),
    .prime_index_o (prime_index_o),
    .last_o        (last_o),
    .none_found_o  (none_found_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Queues one record per prime up to the clipped limit, or a none record below 2.
  function automatic void predict_primes(input value_t lim);
    int unsigned top;
    int unsigned cand;
    int unsigned mult;
    int unsigned count;
    prime_rec_t  rec;
    top = (lim > value_t'(MaxN)) ? MaxN : int'(lim);
    if (top < FirstCand) begin
      rec = '{prime: '0, position: '0, is_last: 1'b1, is_none: 1'b1};
      primes_due.push_back(rec);
      return;
    end
    for (int k = 0; k <= MaxN; k++) composite_free[k] = 1'b1;
    count = 0;
    for (cand = FirstCand; cand <= top; cand++) begin
      if (composite_free[cand]) begin
        count++;
        rec = '{prime: value_t'(cand), position: index_t'(count), is_last: 1'b0,
                is_none: 1'b0};
        primes_due.push_back(rec);
        for (mult = cand; mult <= top; mult += cand) composite_free[mult] = 1'b0;
      end
    end
    primes_due[primes_due.size() - 1].is_last = 1'b1;
  endfunction

  // Offers one limit, with a random gap whenever the current burst runs out.
  task automatic send_limit(input value_t lim);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
    in_valid_i    <= 1'b1;
    upper_limit_i <= lim;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_primes(lim);
    burst_left--;
  endtask

  task automatic test_small_limits();
    for (int k = 0; k <= 5; k++) send_limit(value_t'(k));
  endtask

  // One bit set at a time, then the store edge, limits that clip, 97 and 100.
  task automatic test_extremes();
    for (int b = 3; b < ValueW - 1; b++) send_limit(value_t'(1 << b));
    send_limit(value_t'(MaxN - 1));
    send_limit(value_t'(MaxN));
    send_limit(value_t'(MaxN + 1));
    send_limit(value_t'(384));
    send_limit('1);
    send_limit(value_t'(97));
    send_limit(value_t'(100));
  endtask

  // The receiver holds off long enough that the block fills and stalls its input.
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int k = 0; k < 6; k++) send_limit(value_t'($urandom_range(20, 60)));
  endtask

  // Mostly small limits keep the run short; a few reach the top and beyond.
  task automatic test_random();
    int unsigned pick;
    for (int k = 0; k < RandItems; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) send_limit(value_t'($urandom_range(0, 1)));
      else if (pick < 65) send_limit(value_t'($urandom_range(2, 48)));
      else if (pick < 90) send_limit(value_t'($urandom_range(49, MaxN)));
      else send_limit(value_t'($urandom_range(MaxN + 1, (1 << ValueW) - 1)));
    end
  endtask

  // Output stalls: a long hold on request, else phases: none, random, fixed duty.
  always @(posedge clk_i) begin : stall_pattern
    int unsigned hold_left;
    int unsigned phase_left;
    int unsigned stall_mode;
    bit          hold_done;
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        phase_left = $urandom_range(20, 200);
      end
      phase_left--;
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ((phase_left % 5) < 2);
      endcase
    end
  end

  always @(posedge clk_i) begin : result_check
    prime_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (primes_due.size() == 0) begin
        $error("unexpected result: prime_value %0d prime_index %0d",
               prime_value_o, prime_index_o);
        error_count++;
      end else begin
        want = primes_due.pop_front();
        if (prime_value_o !== want.prime) begin
          $error("prime_value: expected %0d, got %0d", want.prime, prime_value_o);
          error_count++;
        end
        if (prime_index_o !== want.position) begin
          $error("prime_index: expected %0d, got %0d", want.position, prime_index_o);
          error_count++;
        end
        if (last_o !== want.is_last) begin
          $error("last: expected %0b, got %0b", want.is_last, last_o);
          error_count++;
        end
        if (none_found_o !== want.is_none) begin
          $error("none_found: expected %0b, got %0b", want.is_none, none_found_o);
          error_count++;
        end
      end
    end
  end

  // Counts cycles without any transfer on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("sieve_prime_lister test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_small_limits();
    test_extremes();
    test_backpressure();
    test_random();
    in_valid_i <= 1'b0;
    while (primes_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (primes_due.size() != 0) begin
      $error("%0d expected results never arrived", primes_due.size());
    end
    if (error_count == 0 && primes_due.size() == 0) begin
      $display("sieve_prime_lister test passed");
    end else begin
      $display("sieve_prime_lister test failed");
    end
    $finish;
  end

endmodule
